@@ rtl/rclc_pkg.sv @@
package rclc_pkg;

	localparam int TIMER_WIDTH_DEF = 16;

	// configuration register widths and indexes
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int THR_W      = 12;
	localparam int MS_W       = 16;
	localparam int BAR_W      = 8;
	localparam int COUNT_W    = 8;

	localparam logic [CFG_IDX_W-1:0] CFG_CENTER_THRESHOLD = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CLICK_TIMEOUT    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FLASH_PERIOD     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_STARTUP_QUIET    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_BAR_COUNT        = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_INIT_DIRECTION   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_INIT_STRING      = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_INIT_BAR         = 3'd7;

	localparam logic [THR_W-1:0] CENTER_THRESHOLD_RST = 12'd1500;
	localparam logic [MS_W-1:0]  CLICK_TIMEOUT_RST    = 16'd750;
	localparam logic [MS_W-1:0]  FLASH_PERIOD_RST     = 16'd500;
	localparam logic [MS_W-1:0]  STARTUP_QUIET_RST    = 16'd2000;
	localparam logic [BAR_W-1:0] BAR_COUNT_RST        = 8'd4 << 1;

	// item opcodes
	localparam logic OP_PULSE = 1'b0;
	localparam logic OP_TICK  = 1'b1;

	// system modes
	localparam logic [1:0] SYS_NORMAL = 2'd0;
	localparam logic [1:0] SYS_SELECT = 2'd1;

	// mode requests
	localparam logic [1:0] MREQ_NONE   = 2'd0;
	localparam logic [1:0] MREQ_NORMAL = 2'd1;
	localparam logic [1:0] MREQ_SELECT = 2'd2;
	localparam logic [1:0] MREQ_CALIB  = 2'd3;

	// click commands
	localparam logic [COUNT_W-1:0] CLK_STEP    = 8'd1;
	localparam logic [COUNT_W-1:0] CLK_BEAM    = 8'd2;
	localparam logic [COUNT_W-1:0] CLK_FLASH   = 8'd3;
	localparam logic [COUNT_W-1:0] CLK_SELECT  = 8'd4;
	localparam logic [COUNT_W-1:0] CLK_CALIB   = 8'd6;
	localparam logic [COUNT_W-1:0] CLK_STRING  = 8'd7;
	localparam logic [COUNT_W-1:0] CLK_REVERSE = 8'd9;

	// light cycle steps
	localparam logic [1:0] STEP_OFF  = 2'd0;
	localparam logic [1:0] STEP_LOW  = 2'd2;
	localparam logic [1:0] STEP_RUN  = 2'd3;

	// light vector bit positions
	localparam int L_CHASSIS = 0;
	localparam int L_TAIL    = 1;
	localparam int L_HLOW    = 2;
	localparam int L_HHIGH   = 3;
	localparam int L_STRING  = 4;
	localparam int LIGHTS_W  = 5;

	typedef logic [LIGHTS_W-1:0] lights_t;

endpackage

@@ rtl/rc_click_light_controller.sv @@
// An accepted input beat passes through the input register, then the result
// register, to its result beat.
// Throughput: one item per cycle while out_ready does not stall the result;
// the state update is a single pass of short logic between the input register and the result register.
// Reset (arst_n low, asynchronous): configuration returns to its defaults,
// timers and click count clear, lights go off, presets load from defaults.
module rc_click_light_controller #(
	parameter int TIMER_WIDTH = rclc_pkg::TIMER_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [rclc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rclc_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           opcode,
	input  logic [11:0]                    pulse_width,
	input  logic [1:0]                     system_mode,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic                           chassis_on,
	output logic                           tail_on,
	output logic                           head_low_on,
	output logic                           head_high_on,
	output logic                           string_on,
	output logic [1:0]                     mode_request,
	output logic [7:0]                     bar_index,
	output logic                           direction_reverse,
	output logic                           save_request,
	output logic                           restart_request,
	output logic [7:0]                     clicks_decoded
);
	import rclc_pkg::*;

	localparam int CMP_W = (TIMER_WIDTH > MS_W) ? TIMER_WIDTH : MS_W;

	// configuration
	logic [THR_W-1:0] thr_q;
	logic [MS_W-1:0]  timeout_q, period_q, startup_q;
	logic [BAR_W-1:0] bar_count_q;

	// state
	logic [TIMER_WIDTH-1:0] up_q, quiet_q, fe_q;
	logic                   last_q;
	logic [COUNT_W-1:0]     cc_q;
	logic [1:0]             step_q;
	logic                   beam_q, flashing_q, phase_q;
	lights_t                lights_q;
	logic [BAR_W-1:0]       sel_q;
	logic                   rev_q, str_q;

	// input register
	logic             valid_s1;
	logic             op_s1;
	logic [THR_W-1:0] pw_s1;
	logic [1:0]       sys_s1;

	logic advance;

	// next state
	logic [TIMER_WIDTH-1:0] up_n, quiet_n, fe_n;
	logic                   last_n, lvl;
	logic [COUNT_W-1:0]     cc_n, decoded;
	logic [1:0]             step_n;
	logic                   beam_n, flashing_n, phase_n;
	lights_t                lights_n;
	logic [BAR_W-1:0]       sel_n, bar_inc;
	logic                   rev_n, str_n;
	logic [1:0]             mreq;
	logic                   save, restart;

	assign advance  = valid_s1 && (!out_valid || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_comb begin
		up_n       = up_q;
		quiet_n    = quiet_q;
		fe_n       = fe_q;
		last_n     = last_q;
		cc_n       = cc_q;
		step_n     = step_q;
		beam_n     = beam_q;
		flashing_n = flashing_q;
		phase_n    = phase_q;
		lights_n   = lights_q;
		sel_n      = sel_q;
		rev_n      = rev_q;
		str_n      = str_q;
		mreq       = MREQ_NONE;
		save       = 1'b0;
		restart    = 1'b0;
		decoded    = '0;
		lvl        = (pw_s1 >= thr_q);
		bar_inc    = sel_q + 8'd1;
		if (op_s1 == OP_PULSE) begin
			if (lvl != last_q) begin
				quiet_n = '0;
				if (cc_q != '1)
					cc_n = cc_q + 8'd1;
			end
			last_n = lvl;
		end else begin
			up_n    = (up_q == '1) ? up_q : up_q + 1'b1;
			quiet_n = (quiet_q == '1) ? quiet_q : quiet_q + 1'b1;
			fe_n    = (fe_q == '1) ? fe_q : fe_q + 1'b1;
			if (CMP_W'(up_n) <= CMP_W'(startup_q))
				cc_n = '0;
			if (CMP_W'(quiet_n) >= CMP_W'(timeout_q) && cc_n != '0) begin
				decoded = cc_n;
				case (cc_n)
					CLK_STEP: begin
						if (sys_s1 == SYS_SELECT) begin
							sel_n = (bar_inc >= bar_count_q) ? '0 : bar_inc;
						end else begin
							step_n = step_q + 2'd1;
							lights_n[L_CHASSIS] = (step_n != STEP_OFF);
							lights_n[L_TAIL]    = (step_n != STEP_OFF);
							if (step_n == STEP_LOW)
								lights_n[L_HLOW] = 1'b1;
							else if (step_n == STEP_RUN)
								lights_n[L_HLOW] = 1'b0;
						end
					end
					CLK_BEAM: begin
						beam_n = !beam_q;
						lights_n[L_HHIGH] = beam_n;
						lights_n[L_HLOW]  = beam_n || (step_q == STEP_LOW);
					end
					CLK_FLASH: begin
						if (flashing_q)
							lights_n[L_CHASSIS] = (step_q != STEP_OFF);
						flashing_n = !flashing_q;
					end
					CLK_SELECT: begin
						if (sys_s1 == SYS_NORMAL) begin
							mreq = MREQ_SELECT;
						end else if (sys_s1 == SYS_SELECT) begin
							mreq = MREQ_NORMAL;
							save = 1'b1;
						end
					end
					CLK_CALIB: begin
						if (sys_s1 == SYS_NORMAL)
							mreq = MREQ_CALIB;
					end
					CLK_STRING: begin
						str_n = !str_q;
						save  = 1'b1;
						lights_n[L_STRING] = str_n;
					end
					CLK_REVERSE: begin
						rev_n   = !rev_q;
						save    = 1'b1;
						restart = 1'b1;
					end
					default: begin
					end
				endcase
				cc_n = '0;
			end
			// chassis toggles at the flash period
			if (flashing_n && CMP_W'(fe_n) >= CMP_W'(period_q)) begin
				lights_n[L_CHASSIS] = phase_q;
				phase_n = !phase_q;
				fe_n    = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q       <= CENTER_THRESHOLD_RST;
			timeout_q   <= CLICK_TIMEOUT_RST;
			period_q    <= FLASH_PERIOD_RST;
			startup_q   <= STARTUP_QUIET_RST;
			bar_count_q <= BAR_COUNT_RST;
			up_q        <= '0;
			quiet_q     <= '0;
			fe_q        <= '0;
			last_q      <= 1'b1;
			cc_q        <= '0;
			step_q      <= STEP_OFF;
			beam_q      <= 1'b0;
			flashing_q  <= 1'b0;
			phase_q     <= 1'b0;
			lights_q    <= '0;
			sel_q       <= '0;
			rev_q       <= 1'b0;
			str_q       <= 1'b0;
			valid_s1    <= 1'b0;
			out_valid   <= 1'b0;
		end else begin
			if (in_ready)
				valid_s1 <= in_valid;
			if (!out_valid || out_ready)
				out_valid <= valid_s1;
			if (advance) begin
				up_q       <= up_n;
				quiet_q    <= quiet_n;
				fe_q       <= fe_n;
				last_q     <= last_n;
				cc_q       <= cc_n;
				step_q     <= step_n;
				beam_q     <= beam_n;
				flashing_q <= flashing_n;
				phase_q    <= phase_n;
				lights_q   <= lights_n;
				sel_q      <= sel_n;
				rev_q      <= rev_n;
				str_q      <= str_n;
			end
			// presets also load their live state at once
			if (cfg_we) begin
				case (cfg_index)
					CFG_CENTER_THRESHOLD: thr_q <= cfg_data[THR_W-1:0];
					CFG_CLICK_TIMEOUT:    timeout_q <= cfg_data[MS_W-1:0];
					CFG_FLASH_PERIOD:     period_q <= cfg_data[MS_W-1:0];
					CFG_STARTUP_QUIET:    startup_q <= cfg_data[MS_W-1:0];
					CFG_BAR_COUNT:        bar_count_q <= cfg_data[BAR_W-1:0];
					CFG_INIT_DIRECTION:   rev_q <= cfg_data[0];
					CFG_INIT_STRING:      str_q <= cfg_data[0];
					CFG_INIT_BAR:         sel_q <= cfg_data[BAR_W-1:0];
					default: begin
					end
				endcase
			end
		end
	end

	// input payload and result payload
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			op_s1  <= opcode;
			pw_s1  <= pulse_width;
			sys_s1 <= system_mode;
		end
		if (advance) begin
			chassis_on        <= lights_n[L_CHASSIS];
			tail_on           <= lights_n[L_TAIL];
			head_low_on       <= lights_n[L_HLOW];
			head_high_on      <= lights_n[L_HHIGH];
			string_on         <= lights_n[L_STRING];
			mode_request      <= mreq;
			bar_index         <= sel_n;
			direction_reverse <= rev_n;
			save_request      <= save;
			restart_request   <= restart;
			clicks_decoded    <= decoded;
		end
	end

	a_restart_saves: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && restart_request |-> save_request && clicks_decoded == CLK_REVERSE)
		else $error("restart request without save on reverse command");

	a_mode_req_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && mode_request != MREQ_NONE |->
			clicks_decoded == CLK_SELECT || clicks_decoded == CLK_CALIB)
		else $error("mode request without a matching click command");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> valid_s1 && out_valid && !out_ready)
		else $error("input stalled while the result side is free");

	a_pulse_no_decode: assert property (@(posedge clk) disable iff (!arst_n)
		advance && op_s1 == OP_PULSE |=> clicks_decoded == '0)
		else $error("clicks decoded on a pulse beat");

	a_step_off_dark: assert property (@(posedge clk) disable iff (!arst_n)
		advance && !flashing_n && step_n == STEP_OFF |=> !chassis_on && !tail_on)
		else $error("chassis or tail lit with the light cycle off");

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
	import rclc_pkg::*;

	localparam int TW = TIMER_WIDTH_DEF;
	localparam logic [TW-1:0] T_MAX = '1;
	localparam logic [1:0] SYS_CALIB = 2'd2;
	localparam logic [1:0] SYS_SPARE = 2'd3;
	localparam int GAP_MAX   = 16;
	localparam int LONG_HOLD = 400;
	localparam int SHOW_MAX  = 10;

	typedef struct packed {
		logic        op;
		logic [11:0] pw;
		logic [1:0]  sys;
		logic [4:0]  gap;
	} rc_item_t;

	typedef struct packed {
		logic       chassis;
		logic       tail;
		logic       head_low;
		logic       head_high;
		logic       str_lamp;
		logic [1:0] mode_req;
		logic [7:0] bar;
		logic       reverse;
		logic       save;
		logic       restart;
		logic [7:0] clicks;
	} lamp_out_t;

	logic                  clk;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic                  opcode = OP_PULSE;
	logic [11:0]           pulse_width = '0;
	logic [1:0]            system_mode = SYS_NORMAL;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic                  chassis_on, tail_on, head_low_on, head_high_on, string_on;
	logic [1:0]            mode_request;
	logic [7:0]            bar_index;
	logic                  direction_reverse, save_request, restart_request;
	logic [7:0]            clicks_decoded;

	rc_click_light_controller dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.opcode(opcode), .pulse_width(pulse_width), .system_mode(system_mode),
		.out_valid(out_valid), .out_ready(out_ready),
		.chassis_on(chassis_on), .tail_on(tail_on), .head_low_on(head_low_on),
		.head_high_on(head_high_on), .string_on(string_on),
		.mode_request(mode_request), .bar_index(bar_index),
		.direction_reverse(direction_reverse), .save_request(save_request),
		.restart_request(restart_request), .clicks_decoded(clicks_decoded)
	);

	// controller copy: configuration
	logic [11:0]   thr_cfg;
	logic [15:0]   timeout_cfg, flash_cfg, startup_cfg;
	logic [7:0]    bars_cfg;
	// controller copy: state
	logic [TW-1:0] uptime, quiet_time, blink_ms;
	logic          level_hi, beam_hi, flash_on, flash_ph, rev_dir, str_mode;
	logic [7:0]    click_cnt, bar_sel;
	logic [1:0]    light_phase;
	lights_t       lamps;

	rc_item_t      pend_q[$];
	lamp_out_t     lamp_exp_q[$];
	rc_item_t      cur_item, tx_head;
	lamp_out_t     got, want;
	int            n_queued = 0, n_accepted = 0, n_checked = 0;
	int            n_decodes = 0, n_settings = 0, errors = 0;
	int            tx_wait = 0, tx_calm = 0, rx_stall = 0, rx_calm = 0;
	bit            tx_idle_en = 1'b1, rx_idle_en = 1'b1;
	bit            hold_go = 1'b0;
	logic          rx_hold = 1'b0;
	logic          gen_level;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic logic [TW-1:0] sat_up(input logic [TW-1:0] v);
		return (v == T_MAX) ? v : v + 1'b1;
	endfunction

	function automatic void reset_controller();
		thr_cfg = CENTER_THRESHOLD_RST;
		timeout_cfg = CLICK_TIMEOUT_RST;
		flash_cfg = FLASH_PERIOD_RST;
		startup_cfg = STARTUP_QUIET_RST;
		bars_cfg = BAR_COUNT_RST;
		uptime = '0;
		quiet_time = '0;
		blink_ms = '0;
		level_hi = 1'b1;
		click_cnt = '0;
		light_phase = STEP_OFF;
		beam_hi = 1'b0;
		flash_on = 1'b0;
		flash_ph = 1'b0;
		lamps = '0;
		bar_sel = '0;
		rev_dir = 1'b0;
		str_mode = 1'b0;
	endfunction

	function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
		case (idx)
			CFG_CENTER_THRESHOLD: thr_cfg = val[11:0];
			CFG_CLICK_TIMEOUT:    timeout_cfg = val;
			CFG_FLASH_PERIOD:     flash_cfg = val;
			CFG_STARTUP_QUIET:    startup_cfg = val;
			CFG_BAR_COUNT:        bars_cfg = val[7:0];
			// presets load their state entry at once
			CFG_INIT_DIRECTION:   rev_dir = val[0];
			CFG_INIT_STRING:      str_mode = val[0];
			CFG_INIT_BAR:         bar_sel = val[7:0];
			default: ;
		endcase
	endfunction

	function automatic lamp_out_t step_controller(input rc_item_t it);
		lamp_out_t r;
		logic lvl;
		r = '0;
		if (it.op == OP_PULSE) begin
			lvl = (it.pw >= thr_cfg);
			if (lvl != level_hi) begin
				quiet_time = '0;
				if (click_cnt != 8'hFF)
					click_cnt = click_cnt + 8'd1;
			end
			level_hi = lvl;
		end else begin
			uptime = sat_up(uptime);
			quiet_time = sat_up(quiet_time);
			blink_ms = sat_up(blink_ms);
			if (uptime <= startup_cfg)
				click_cnt = '0;
			if (quiet_time >= timeout_cfg && click_cnt != 0) begin
				r.clicks = click_cnt;
				case (click_cnt)
					CLK_STEP: begin
						if (it.sys == SYS_SELECT) begin
							bar_sel = bar_sel + 8'd1;
							if (bar_sel >= bars_cfg)
								bar_sel = '0;
						end else begin
							light_phase = light_phase + 2'd1;
							if (light_phase == STEP_OFF) begin
								lamps[L_CHASSIS] = 1'b0;
								lamps[L_TAIL] = 1'b0;
							end else begin
								lamps[L_CHASSIS] = 1'b1;
								lamps[L_TAIL] = 1'b1;
								if (light_phase == STEP_LOW)
									lamps[L_HLOW] = 1'b1;
								else if (light_phase == STEP_RUN)
									lamps[L_HLOW] = 1'b0;
							end
						end
					end
					CLK_BEAM: begin
						beam_hi = ~beam_hi;
						lamps[L_HHIGH] = beam_hi;
						lamps[L_HLOW] = beam_hi | (light_phase == STEP_LOW);
					end
					CLK_FLASH: begin
						if (flash_on) begin
							lamps[L_CHASSIS] = (light_phase != STEP_OFF);
							flash_on = 1'b0;
						end else begin
							flash_on = 1'b1;
						end
					end
					CLK_SELECT: begin
						if (it.sys == SYS_NORMAL) begin
							r.mode_req = MREQ_SELECT;
						end else if (it.sys == SYS_SELECT) begin
							r.save = 1'b1;
							r.mode_req = MREQ_NORMAL;
						end
					end
					CLK_CALIB: begin
						if (it.sys == SYS_NORMAL)
							r.mode_req = MREQ_CALIB;
					end
					CLK_STRING: begin
						str_mode = ~str_mode;
						r.save = 1'b1;
						lamps[L_STRING] = str_mode;
					end
					CLK_REVERSE: begin
						rev_dir = ~rev_dir;
						r.save = 1'b1;
						r.restart = 1'b1;
					end
					default: ;
				endcase
				click_cnt = '0;
			end
			if (flash_on && blink_ms >= flash_cfg) begin
				lamps[L_CHASSIS] = flash_ph;
				flash_ph = ~flash_ph;
				blink_ms = '0;
			end
		end
		r.chassis = lamps[L_CHASSIS];
		r.tail = lamps[L_TAIL];
		r.head_low = lamps[L_HLOW];
		r.head_high = lamps[L_HHIGH];
		r.str_lamp = lamps[L_STRING];
		r.bar = bar_sel;
		r.reverse = rev_dir;
		return r;
	endfunction

	function automatic string show(input lamp_out_t v);
		return $sformatf({"ch %b tl %b hl %b hh %b st %b mode %0d bar %0d",
			" rev %b save %b rst %b clicks %0d"},
			v.chassis, v.tail, v.head_low, v.head_high, v.str_lamp, v.mode_req, v.bar,
			v.reverse, v.save, v.restart, v.clicks);
	endfunction

	// driver: present pending beats, each after its own idle gap
	always @(posedge clk) begin
		if (in_valid && in_ready) begin
			lamp_exp_q.push_back(step_controller(cur_item));
			n_accepted++;
		end
		if (!in_valid || in_ready) begin
			if (pend_q.size() != 0) begin
				tx_head = pend_q[0];
				if (tx_wait >= tx_head.gap) begin
					cur_item = pend_q.pop_front();
					tx_wait = 0;
					in_valid <= 1'b1;
					opcode <= cur_item.op;
					pulse_width <= cur_item.pw;
					system_mode <= cur_item.sys;
				end else begin
					tx_wait++;
					in_valid <= 1'b0;
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// monitor: check each result beat against the oldest expectation
	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			got = {chassis_on, tail_on, head_low_on, head_high_on, string_on, mode_request,
				bar_index, direction_reverse, save_request, restart_request, clicks_decoded};
			if (lamp_exp_q.size() == 0) begin
				if (errors < SHOW_MAX)
					$display("%0t: result beat with nothing expected: %s", $time, show(got));
				errors++;
			end else begin
				want = lamp_exp_q.pop_front();
				n_checked++;
				if (want.clicks != 0)
					n_decodes++;
				if (got !== want) begin
					if (errors < SHOW_MAX) begin
						$display("%0t: mismatch on result %0d", $time, n_checked);
						$display("  want %s", show(want));
						$display("  got  %s", show(got));
					end
					errors++;
				end
			end
			if (rx_calm > 0) begin
				rx_calm--;
				rx_stall = 0;
			end else if (!rx_idle_en) begin
				rx_stall = 0;
			end else if ($urandom_range(0, 99) < 3) begin
				rx_calm = $urandom_range(20, 80);
				rx_stall = 0;
			end else begin
				rx_stall = $urandom_range(0, GAP_MAX);
			end
		end
		if (rx_stall > 0) begin
			rx_stall--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= !rx_hold;
		end
	end

	// long receiver hold-off so the block backs up and stalls its input
	initial begin
		wait (hold_go);
		@(posedge clk);
		rx_hold <= 1'b1;
		repeat (LONG_HOLD) @(posedge clk);
		rx_hold <= 1'b0;
	end

	initial begin
		#20_000_000;
		$display("tb_top failed");
		$finish;
	end

	function automatic logic [4:0] draw_gap();
		if (!tx_idle_en)
			return '0;
		if (tx_calm > 0) begin
			tx_calm--;
			return '0;
		end
		if ($urandom_range(0, 99) < 3) begin
			tx_calm = $urandom_range(20, 80);
			return '0;
		end
		return 5'($urandom_range(0, GAP_MAX));
	endfunction

	function automatic logic [1:0] rand_sys();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40)
			return SYS_NORMAL;
		if (r < 80)
			return SYS_SELECT;
		if (r < 92)
			return SYS_CALIB;
		return SYS_SPARE;
	endfunction

	// pulse width that slices to the wanted level, often close to the threshold
	function automatic logic [11:0] width_at(input logic hi);
		int t;
		t = thr_cfg;
		if (hi) begin
			if ($urandom_range(0, 1) == 0)
				return 12'(t + $urandom_range(0, (4095 - t < 8) ? 4095 - t : 8));
			return 12'($urandom_range(t, 4095));
		end
		if (t == 0)
			return 12'($urandom_range(0, 4095));
		if ($urandom_range(0, 1) == 0)
			return 12'(t - 1 - $urandom_range(0, (t - 1 < 8) ? t - 1 : 8));
		return 12'($urandom_range(0, t - 1));
	endfunction

	task automatic queue_item(input logic op, input logic [11:0] pw, input logic [1:0] sys);
		rc_item_t it;
		it.op = op;
		it.pw = pw;
		it.sys = sys;
		it.gap = draw_gap();
		if (op == OP_PULSE)
			gen_level = (pw >= thr_cfg);
		pend_q.push_back(it);
		n_queued++;
	endtask

	task automatic queue_tick(input logic [1:0] sys);
		queue_item(OP_TICK, 12'($urandom_range(0, 4095)), sys);
	endtask

	// a run of level changes, then enough quiet ticks to decode them
	task automatic click_burst(input int clicks, input logic [1:0] sys);
		int tail;
		for (int i = 0; i < clicks; i++) begin
			queue_item(OP_PULSE, width_at(!gen_level), rand_sys());
			if ($urandom_range(0, 99) < 15)
				queue_item(OP_PULSE, width_at(gen_level), rand_sys());
			if (timeout_cfg >= 2 && $urandom_range(0, 99) < 20)
				repeat ($urandom_range(1, (timeout_cfg - 1 < 6) ? timeout_cfg - 1 : 6))
					queue_tick(rand_sys());
		end
		tail = timeout_cfg + $urandom_range(0, 3);
		if (tail == 0)
			tail = 1;
		repeat (tail) queue_tick(sys);
	endtask

	task automatic random_traffic(input int target);
		int start;
		start = n_queued;
		while (n_queued - start < target) begin
			if ($urandom_range(0, 99) < 80) begin
				if ($urandom_range(0, 99) < 90)
					click_burst($urandom_range(1, 10), rand_sys());
				else
					click_burst($urandom_range(11, 20), rand_sys());
			end else begin
				repeat ($urandom_range(1, 4))
					queue_item(1'($urandom_range(0, 1)), 12'($urandom_range(0, 4095)),
						2'($urandom_range(0, 3)));
			end
		end
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= 16'(val);
		apply_reg(idx, 16'(val));
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic setup(input int thr, input int tmo, input int fl, input int st,
		input int bars, input int dir, input int strm, input int bar0);
		write_reg(CFG_CENTER_THRESHOLD, thr);
		write_reg(CFG_CLICK_TIMEOUT, tmo);
		write_reg(CFG_FLASH_PERIOD, fl);
		write_reg(CFG_STARTUP_QUIET, st > 65535 ? 65535 : st);
		write_reg(CFG_BAR_COUNT, bars);
		write_reg(CFG_INIT_DIRECTION, dir);
		write_reg(CFG_INIT_STRING, strm);
		write_reg(CFG_INIT_BAR, bar0);
		gen_level = level_hi;
		n_settings++;
	endtask

	task automatic wait_idle();
		while (n_accepted != n_queued || n_checked != n_accepted)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	initial begin
		reset_controller();
		gen_level = 1'b1;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// defaults: field extremes while the start-up quiet time discards counts
		queue_item(OP_PULSE, 12'd0, SYS_NORMAL);
		queue_item(OP_PULSE, 12'hFFF, SYS_SELECT);
		queue_item(OP_PULSE, CENTER_THRESHOLD_RST - 12'd1, SYS_CALIB);
		queue_item(OP_PULSE, CENTER_THRESHOLD_RST, SYS_SPARE);
		queue_item(OP_PULSE, 12'hFFF, SYS_NORMAL);
		queue_item(OP_TICK, 12'd0, SYS_NORMAL);
		queue_item(OP_TICK, 12'hFFF, SYS_SPARE);
		wait_idle();

		// short timeout, counts kept: step, bar wrap, beam, flashing
		setup(1500, 1, 2, 0, 3, 1, 1, 2);
		click_burst(1, SYS_SELECT);
		click_burst(1, SYS_NORMAL);
		click_burst(2, SYS_NORMAL);
		click_burst(3, SYS_NORMAL);
		repeat (4) queue_tick(SYS_NORMAL);
		click_burst(3, SYS_NORMAL);
		wait_idle();

		for (int p = 0; p < 6; p++) begin
			case (p)
				0: begin
					setup(1500, 3, 4, uptime + 20, 8, $urandom_range(0, 1),
						$urandom_range(0, 1), $urandom_range(0, 7));
					click_burst(260, SYS_NORMAL);
				end
				1: setup(0, 1, 1, 0, 1, 1, 0, 0);
				2: setup(4095, 0, 65535, 0, 255, 0, 1, 254);
				default: setup($urandom_range(0, 4095), $urandom_range(1, 10),
					$urandom_range(1, 20), uptime + $urandom_range(0, 50),
					$urandom_range(0, 255), $urandom_range(0, 1), $urandom_range(0, 1),
					$urandom_range(0, 254));
			endcase
			random_traffic(p == 1 ? 60 : 300);
			if (p == 4)
				hold_go = 1'b1;
			wait_idle();
		end

		// run every timer into saturation with the longest timeout, no idling
		tx_idle_en = 1'b0;
		rx_idle_en = 1'b0;
		setup(1500, 65535, 65535, 0, 8, 0, 0, 5);
		click_burst(2, SYS_NORMAL);
		wait_idle();
		tx_idle_en = 1'b1;
		rx_idle_en = 1'b1;

		// start-up quiet at the saturated uptime discards counts for good
		setup(1500, 1, 1, 65535, 8, 1, 1, 0);
		random_traffic(40);
		wait_idle();

		// one below saturation lets counts through again
		setup(2048, 2, 3, 65534, 4, 0, 0, 3);
		random_traffic(60);
		wait_idle();

		repeat (10) @(posedge clk);
		$display("covered %0d items over %0d register settings, %0d click decodes",
			n_accepted, n_settings, n_decodes);
		$display("%0d result mismatches, %0d expectations outstanding", errors,
			lamp_exp_q.size());
		if (errors == 0 && lamp_exp_q.size() == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule
